### rtl/dwd_pkg.sv
// ----------------------------------------------------------------------------
// dwd_pkg
// Shared types and constants for the double-word divider.
// ----------------------------------------------------------------------------
package dwd_pkg;

  // Working word width (16..64); the ports stay at IO_BITS.
  localparam int WORD_BITS = 64;
  localparam int IO_BITS   = 64;
  localparam int CNT_W     = $clog2(WORD_BITS);

  typedef logic [WORD_BITS-1:0] word_t;
  typedef logic [IO_BITS-1:0]   io_word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_CHECK,
    ST_DIVIDE,
    ST_DONE
  } state_t;

  // Sequencer to datapath
  typedef struct packed {
    logic load;
    logic reduce;
    logic shift;
    logic set_dz;
    logic set_ovf;
    logic emit;
  } ctrl_t;

  // Datapath to sequencer
  typedef struct packed {
    logic dv_zero;
    logic ge;
  } status_t;

endpackage

### rtl/dwd_alu.sv
// ----------------------------------------------------------------------------
// dwd_alu
// Shared compare-and-subtract unit: one wide subtract per cycle.
// ----------------------------------------------------------------------------
module dwd_alu
  import dwd_pkg::*;
(
  input  logic [WORD_BITS:0] a_i,
  input  word_t              dv_i,
  output word_t              diff_o,
  output logic               ge_o
);

  // A carry bit in a_i makes it exceed any divisor, so the wide compare covers it.
  assign ge_o   = (a_i >= {1'b0, dv_i});
  assign diff_o = a_i[WORD_BITS-1:0] - dv_i;

endmodule

### rtl/dwd_seq.sv
// ----------------------------------------------------------------------------
// dwd_seq
// Sequencer: divisor zero check and reduce, overflow check, one quotient bit per cycle, finish.
// ----------------------------------------------------------------------------
module dwd_seq
  import dwd_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    start,
  input  status_t status_i,
  output ctrl_t   ctrl_o,
  output logic    busy_o
);

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r,   cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_REDUCE;
        end
      end
      ST_REDUCE: begin
        state_nxt = status_i.dv_zero ? ST_DONE : ST_CHECK;
      end
      ST_CHECK: begin
        if (status_i.ge) begin
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_DIVIDE;
          cnt_nxt   = CNT_W'(WORD_BITS - 1);
        end
      end
      ST_DIVIDE: begin
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Outputs
  always_comb begin
    ctrl_o = '0;
    unique case (state_r)
      ST_IDLE: begin
        ctrl_o.load = start;
      end
      ST_REDUCE: begin
        ctrl_o.reduce = !status_i.dv_zero;
        ctrl_o.set_dz = status_i.dv_zero;
      end
      ST_CHECK: begin
        ctrl_o.set_ovf = status_i.ge;
      end
      ST_DIVIDE: begin
        ctrl_o.shift = 1'b1;
      end
      ST_DONE: begin
        ctrl_o.emit = 1'b1;
      end
      default: begin
        ctrl_o = '0;
      end
    endcase
  end

  assign busy_o = (state_r != ST_IDLE);

endmodule

### rtl/double_word_divider_top.sv
// ----------------------------------------------------------------------------
// double_word_divider_top
// Unsigned 128-by-64 division giving a 64-bit quotient, one bit per cycle.
// ----------------------------------------------------------------------------
// A transfer is taken at a rising edge with start high and busy low. The
// divisor is zero-checked, the high word is reduced by one subtraction if it
// is not below the divisor, and if it is still not below, the quotient
// saturates to all ones with quotient_overflow set. Otherwise a single shared
// compare-and-subtract unit retires one quotient bit per cycle, MSB first.
// The result on the out_ ports is marked by out_valid for exactly one cycle;
// there is no back-pressure, so sample it then or lose it. A zero divisor
// sets out_divide_by_zero and saturates the quotient to all ones too. busy
// drops in the cycle the result is shown, so a new transfer may follow right
// after. Input bits above WORD_BITS are ignored and the quotient is
// zero-extended to 64 bits.
// ----------------------------------------------------------------------------
module double_word_divider_top
  import dwd_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  io_word_t in_dividend_high,
  input  io_word_t in_dividend_low,
  input  io_word_t in_divisor,
  output logic     out_valid,
  output io_word_t out_quotient,
  output logic     out_divide_by_zero,
  output logic     out_quotient_overflow
);

  ctrl_t   ctrl;
  status_t status;

  // Working registers: partial remainder, low word that turns into the
  // quotient as bits shift in, and the divisor.
  word_t rem_r;
  word_t lo_r;
  word_t dv_r;
  logic  dz_r;
  logic  ovf_r;

  logic     out_valid_r;
  io_word_t out_quotient_r;
  logic     out_dz_r;
  logic     out_ovf_r;

  logic [WORD_BITS:0] alu_a;
  word_t              alu_diff;
  logic               alu_ge;

  dwd_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .status_i (status),
    .ctrl_o   (ctrl),
    .busy_o   (busy)
  );

  // Shift the next dividend bit in while dividing; plain compare otherwise.
  assign alu_a = ctrl.shift ? {rem_r, lo_r[WORD_BITS-1]} : {1'b0, rem_r};

  dwd_alu u_alu (
    .a_i    (alu_a),
    .dv_i   (dv_r),
    .diff_o (alu_diff),
    .ge_o   (alu_ge)
  );

  assign status.dv_zero = (dv_r == '0);
  assign status.ge      = alu_ge;

  // Datapath
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      rem_r <= in_dividend_high[WORD_BITS-1:0];
      lo_r  <= in_dividend_low[WORD_BITS-1:0];
      dv_r  <= in_divisor[WORD_BITS-1:0];
    end else if (ctrl.reduce) begin
      // single pre-subtraction of the high word
      if (alu_ge) begin
        rem_r <= alu_diff;
      end
    end else if (ctrl.shift) begin
      rem_r <= alu_ge ? alu_diff : alu_a[WORD_BITS-1:0];
      lo_r  <= {lo_r[WORD_BITS-2:0], alu_ge};
    end
  end

  // Error flags: clear on a new transfer, set by the sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dz_r  <= 1'b0;
      ovf_r <= 1'b0;
    end else if (ctrl.load) begin
      dz_r  <= 1'b0;
      ovf_r <= 1'b0;
    end else begin
      if (ctrl.set_dz) begin
        dz_r <= 1'b1;
      end
      if (ctrl.set_ovf) begin
        ovf_r <= 1'b1;
      end
    end
  end

  // Result register: strobe for one cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= ctrl.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.emit) begin
      out_quotient_r <= (dz_r || ovf_r) ? IO_BITS'({WORD_BITS{1'b1}}) : IO_BITS'(lo_r);
      out_dz_r       <= dz_r;
      out_ovf_r      <= ovf_r;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_quotient          = out_quotient_r;
  assign out_divide_by_zero    = out_dz_r;
  assign out_quotient_overflow = out_ovf_r;

endmodule

### rtl/dwd_checker.sv
// ----------------------------------------------------------------------------
// dwd_checker
// Port-level checks on the divider's command and result timing.
// ----------------------------------------------------------------------------
module dwd_checker
  import dwd_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     start,
  input logic     busy,
  input logic     out_valid,
  input io_word_t out_quotient,
  input logic     out_divide_by_zero,
  input logic     out_quotient_overflow
);

  // An accepted transfer makes the block busy.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after accepted transfer");

  // The result appears exactly when busy drops.
  a_fell_valid: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("busy dropped without a result");

  // A result is a single-cycle strobe and never overlaps work.
  a_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!busy && !$past(out_valid)))
    else $error("result strobe longer than one cycle or shown while busy");

  // Error flags are exclusive and saturate the quotient.
  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_divide_by_zero || out_quotient_overflow)) |->
      (!(out_divide_by_zero && out_quotient_overflow) &&
       out_quotient == IO_BITS'({WORD_BITS{1'b1}})))
    else $error("error result with bad quotient or both flags");

endmodule

bind double_word_divider_top dwd_checker u_dwd_checker (.*);
